### hdl/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// pcxrle_pkg : shared types and constants of the PCX-style line encoder
// Holds the run marker constants, the encoder state record and the result
// record that the code calculator hands to the output buffer.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

	localparam logic [7:0] RUN_MARK = 8'hC0;
	localparam logic [5:0] RUN_MAX  = 6'h3F;
	localparam logic [7:0] RUN_FULL = 8'hFF;

	localparam int unsigned MAX_CODES = 4;

	// encoder state between input words
	typedef struct packed {
		logic [7:0] held;
		logic [5:0] count;
		logic       holding;
	} pcxrle_state_t;

	// code words caused by one input word
	typedef struct packed {
		logic [MAX_CODES-1:0][7:0] code;
		logic [2:0]                num;
	} pcxrle_res_t;

endpackage

### hdl/pcxrle_calc.sv
// ----------------------------------------------------------------------------
// pcxrle_calc : code calculator
// From the held state and one pixel word, works out up to four code words
// and the state left behind, in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module pcxrle_calc (
	input  logic [7:0]              pixel_byte,
	input  logic                    line_end,
	input  pcxrle_pkg::pcxrle_state_t st,
	output pcxrle_pkg::pcxrle_res_t   res,
	output pcxrle_pkg::pcxrle_state_t st_nxt
);
	import pcxrle_pkg::*;

	logic [5:0] cnt;
	logic [2:0] n;
	logic [MAX_CODES-1:0][7:0] codes;

	always_comb begin
		cnt   = st.count;
		n     = 3'd0;
		codes = '0;
		// close, start or extend the pending run, or send a held literal
		if (st.holding) begin
			if (cnt != 6'd0) begin
				if (st.held == pixel_byte) begin
					if (cnt == RUN_MAX) begin
						codes[n[1:0]] = RUN_FULL;
						n = n + 3'd1;
						codes[n[1:0]] = st.held;
						n = n + 3'd1;
						cnt = 6'd1;
					end else begin
						cnt = cnt + 6'd1;
					end
				end else begin
					codes[n[1:0]] = RUN_MARK | {2'b00, cnt};
					n = n + 3'd1;
					codes[n[1:0]] = st.held;
					n = n + 3'd1;
					cnt = 6'd0;
				end
			end else begin
				if (st.held == pixel_byte) begin
					cnt = 6'd2;
				end else begin
					codes[n[1:0]] = st.held;
					n = n + 3'd1;
				end
			end
		end
		// escape a lone byte that looks like a marker
		if (cnt == 6'd0 && (pixel_byte & RUN_MARK) == RUN_MARK)
			cnt = 6'd1;
		// flush at the end of the line
		if (line_end) begin
			if (cnt != 6'd0) begin
				codes[n[1:0]] = RUN_MARK | {2'b00, cnt};
				n = n + 3'd1;
			end
			codes[n[1:0]] = pixel_byte;
			n = n + 3'd1;
			st_nxt = '0;
		end else begin
			st_nxt.held    = pixel_byte;
			st_nxt.count   = cnt;
			st_nxt.holding = 1'b1;
		end
		res.code = codes;
		res.num  = n;
	end

endmodule

### hdl/pcxrle_outbuf.sv
// ----------------------------------------------------------------------------
// pcxrle_outbuf : result register and serialiser
// Holds the code words of one input word, sends them one per cycle while
// code_ready is high and flags the last. Reports when it can take a fresh set.
// ----------------------------------------------------------------------------
module pcxrle_outbuf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  pcxrle_pkg::pcxrle_res_t res,
	output logic                    free,
	output logic                    code_valid,
	input  logic                    code_ready,
	output logic [7:0]              code_byte,
	output logic                    last_of_run
);
	import pcxrle_pkg::*;

	logic [MAX_CODES-1:0][7:0] code_q;
	logic [2:0]                num_q;
	logic [1:0]                idx_q;
	logic                      valid_q;
	logic                      at_last;

	// flag the final word of the held set
	assign at_last     = ({1'b0, idx_q} == (num_q - 3'd1));
	assign free        = !valid_q || (code_ready && at_last);
	assign code_valid  = valid_q;
	assign code_byte   = code_q[idx_q];
	assign last_of_run = at_last;

	// advance through the set, reload when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (free) begin
			valid_q <= load && (res.num != 3'd0);
			idx_q   <= '0;
		end else if (code_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// hold the payload of a fresh set
	always_ff @(posedge clk) begin
		if (free && load) begin
			code_q <= res.code;
			num_q  <= res.num;
		end
	end

endmodule

### hdl/pcx_style_rle_line_encoder_top.sv
// ----------------------------------------------------------------------------
// pcx_style_rle_line_encoder_top : PCX-style run-length line encoder
// Takes one pixel word per handshake and sends the compressed stream one
// code word per handshake.
// ----------------------------------------------------------------------------
// An input word is registered, then the calculator works out in
// combinational logic its code words (none to four) and the run state it
// leaves, and the set drops into the result register once that is free,
// from which one code word leaves per cycle while code_ready is high. A
// word makes two code words for a run or an escaped byte closing, one for
// a literal, up to four when a line ends, and none when it only extends a
// run. A new pixel word is taken while the previous set drains.
module pcx_style_rle_line_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  logic [7:0] pixel_byte,
	input  logic       line_end,
	output logic       code_valid,
	input  logic       code_ready,
	output logic [7:0] code_byte,
	output logic       last_of_run
);
	import pcxrle_pkg::*;

	logic          valid_s1;
	logic [7:0]    pixel_byte_s1;
	logic          line_end_s1;
	pcxrle_state_t state_q;
	pcxrle_state_t state_nxt;
	pcxrle_res_t   res;
	logic          free;
	logic          advance;

	assign advance   = valid_s1 && free;
	assign pix_ready = !valid_s1 || free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			pixel_byte_s1 <= pixel_byte;
			line_end_s1   <= line_end;
		end
	end

	// run state, updated as each word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	pcxrle_calc u_calc (
		.pixel_byte (pixel_byte_s1),
		.line_end   (line_end_s1),
		.st         (state_q),
		.res        (res),
		.st_nxt     (state_nxt)
	);

	pcxrle_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (valid_s1),
		.res         (res),
		.free        (free),
		.code_valid  (code_valid),
		.code_ready  (code_ready),
		.code_byte   (code_byte),
		.last_of_run (last_of_run)
	);

endmodule

### hdl/pcxrle_chk.sv
// ----------------------------------------------------------------------------
// pcxrle_chk : port checker for the line encoder
// Watches the ports of the top level for flow and framing slips.
// ----------------------------------------------------------------------------
module pcxrle_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_ready,
	input logic       code_valid,
	input logic       code_ready,
	input logic [7:0] code_byte,
	input logic       last_of_run
);

	// a stalled code word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_ready |=> code_valid && $stable(code_byte))
		else $error("code word dropped while stalled");

	// a set is sent without gaps: a non-final word is followed at once
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_ready && !last_of_run |=> code_valid)
		else $error("gap inside a code set");

	// input back-pressure only while output is pending
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> code_valid)
		else $error("input stalled with nothing to send");

	// input side is free as reset is released
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> pix_ready)
		else $error("input not ready after reset");

endmodule

bind pcx_style_rle_line_encoder_top pcxrle_chk u_pcxrle_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_ready   (pix_ready),
	.code_valid  (code_valid),
	.code_ready  (code_ready),
	.code_byte   (code_byte),
	.last_of_run (last_of_run)
);
